### design/wavetable_sound_mixer_defines.svh
// Assertion macros for the wavetable mixer checker.
`ifndef WAVETABLE_SOUND_MIXER_DEFINES_SVH
`define WAVETABLE_SOUND_MIXER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define WSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define WSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/wsm_pkg.sv
// Types, constants and field layouts for the wavetable sound mixer.
package wsm_pkg;

  localparam int NUM_CH      = 4;
  localparam int CH_W        = 2;
  localparam int STEP_W      = 5;
  localparam int PHASE_W     = 16;
  localparam int FREQ_W      = 11;
  localparam int DIVISOR_W   = FREQ_W + 1;
  localparam int VOL_W       = 4;
  localparam int CH_SET_W    = 20;
  localparam int SWEEP_SET_W = 22;
  localparam int MIX_SET_W   = 7;
  localparam int MVOL_W      = 6;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 22;
  localparam int WADDR_W     = 6;
  localparam int WDATA_W     = 8;
  localparam int VOICE_W     = 8;
  localparam int SAMPLE_W    = 16;
  localparam int SWEEP_CNT_W = 14;
  localparam int TICK_SHIFT  = 8;
  // Dividend is phase << 8; two quotient bits per cycle.
  localparam int DIV_STEPS   = (PHASE_W + TICK_SHIFT) / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [DIVISOR_W-1:0] FREQ_BASE   = DIVISOR_W'(2048);
  localparam logic [3:0]           STEP_CENTRE = 4'd8;
  localparam logic [WDATA_W-1:0]   WAVE_RESET  = 8'h88;

  // Channel settings fields
  localparam int CH_FREQ_LSB = 0;
  localparam int CH_LVOL_LSB = 11;
  localparam int CH_RVOL_LSB = 15;
  localparam int CH_ON_BIT   = 19;

  // Mix settings fields
  localparam int MIX_VOICE_ON  = 0;
  localparam int MIX_EN_LSB    = 1;
  localparam int MIX_VOICE_EN  = 5;
  localparam int MIX_SWEEP_EN  = 6;

  // Sweep settings fields
  localparam int SWP_ON_BIT  = 0;
  localparam int SWP_STEP_LSB = 1;
  localparam int SWP_PER_LSB = 9;

  localparam logic [CH_W-1:0] VOICE_CH = 2'd1;
  localparam logic [CH_W-1:0] SWEEP_CH = 2'd2;
  localparam logic [CH_W-1:0] LAST_CH  = 2'd3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CH0   = 3'd0,
    REG_CH1   = 3'd1,
    REG_CH2   = 3'd2,
    REG_CH3   = 3'd3,
    REG_SWEEP = 3'd4,
    REG_MIX   = 3'd5,
    REG_MVOL  = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_WRITE = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_READ,
    ST_ACC,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [PHASE_W-1:0]   phase;
    logic [DIVISOR_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] step;
  } div_rsp_t;

endpackage

### design/wsm_req_if.sv
// Request channel: sample ticks and wave memory writes.
interface wsm_req_if;
  import wsm_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [WADDR_W-1:0] wave_addr;
  logic [WDATA_W-1:0] wave_data;
  logic [VOICE_W-1:0] voice_sample;

  modport source (output valid, req_type, wave_addr, wave_data, voice_sample,
                  input ready);
  modport sink (input valid, req_type, wave_addr, wave_data, voice_sample,
                output ready);
endinterface

### design/wsm_res_if.sv
// Result channel: mixed left and right samples.
interface wsm_res_if;
  import wsm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

### design/wsm_cfg_if.sv
// Configuration write channel: register index and write data.
interface wsm_cfg_if;
  import wsm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### design/wsm_div.sv
// Shared radix-4 restoring divider: low five bits of (phase << 8) / divisor.
module wsm_div (
  input  logic              clk,
  input  logic              rst,
  input  wsm_pkg::div_cmd_t cmd,
  output wsm_pkg::div_rsp_t rsp
);
  import wsm_pkg::*;

  localparam int NUM_W = PHASE_W + TICK_SHIFT;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     num;
  logic [DIVISOR_W-1:0] div;
  logic [DIVISOR_W-1:0] rem;
  logic [STEP_W-1:0]    quot;

  logic [DIVISOR_W:0]   r1, r2, dext;
  logic                 ge1, ge2;
  logic [DIVISOR_W-1:0] r1s, r2s;

  // Two dependent shift-compare-subtract steps per cycle
  always_comb begin
    dext = {1'b0, div};
    r1   = {rem, num[NUM_W-1]};
    ge1  = (r1 >= dext);
    r1s  = ge1 ? DIVISOR_W'(r1 - dext) : DIVISOR_W'(r1);
    r2   = {r1s, num[NUM_W-2]};
    ge2  = (r2 >= dext);
    r2s  = ge2 ? DIVISOR_W'(r2 - dext) : DIVISOR_W'(r2);
  end

  // Sequence control: stay busy until the last step is counted, then pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift two bits a cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num  <= {cmd.phase, TICK_SHIFT'(0)};
      div  <= cmd.divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      num  <= {num[NUM_W-3:0], 2'b00};
      rem  <= r2s;
      quot <= {quot[STEP_W-3:0], ge1, ge2};
    end
  end

  assign rsp.done = done;
  assign rsp.step = quot;

endmodule

### design/wavetable_sound_mixer.sv
// Top level of the four-channel wavetable sound mixer.
//
//   channel  direction  payload
//   cfg      in         addr (register index), data
//   req      in         req_type, wave_addr, wave_data, voice_sample
//   res      out        left_sample, right_sample
//
// A wave write leaves the block idle, so it stays ready for the next request.
// A sample tick walks the channels in order through check, divide, read and
// accumulate, skips the shared divider for a silent channel, then mixes the sums.
// The result sits in an output register, so writes and the next tick are taken
// while it waits; the final mix stalls only if the previous result is still held.
// Reset is synchronous; wave memory reads as 8 per step until a byte is written.
module wavetable_sound_mixer (
  input logic     clk,
  input logic     rst,
  wsm_cfg_if.sink cfg,
  wsm_req_if.sink req,
  wsm_res_if.source res
);
  import wsm_pkg::*;

  localparam int WORDS  = 1 << WADDR_W;
  localparam int SUM_W  = 11;
  localparam int TOT_W  = SUM_W + 1;
  localparam int PROD_W = TOT_W + MVOL_W + 1;

  // Configuration registers
  logic [CH_SET_W-1:0]    ch_set [NUM_CH];
  logic [SWEEP_SET_W-1:0] sweep_set;
  logic [MIX_SET_W-1:0]   mix_set;
  logic [MVOL_W-1:0]      mvol;

  // Channel and sweep state
  logic [PHASE_W-1:0]            phase_count [NUM_CH];
  logic [STEP_W-1:0]             last_step [NUM_CH];
  logic [FREQ_W-1:0]             swept_freq;
  logic signed [SWEEP_CNT_W-1:0] sweep_cnt;

  // Wave memory, one byte per step pair
  logic [WDATA_W-1:0] wmem [WORDS];
  logic [WORDS-1:0]   wvalid;
  logic [WDATA_W-1:0] rd_byte;
  logic               rd_ok;

  // Sequencer and datapath registers
  state_t                     state, state_next;
  logic [CH_W-1:0]            ch;
  logic [STEP_W-1:0]          idx;
  logic signed [SUM_W-1:0]    lsum, rsum;
  logic signed [VOICE_W-1:0]  voice;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_left, out_right;

  div_cmd_t div_cmd;
  div_rsp_t div_rsp;

  logic                       req_fire, tick_fire, write_fire, out_free;
  logic [CH_SET_W-1:0]        cur_set;
  logic                       voice_on, sweep_on, ch_active;
  logic [FREQ_W-1:0]          cur_freq;
  logic [3:0]                 nib;
  logic signed [4:0]          step_val;
  logic signed [9:0]          lprod, rprod;
  logic signed [TOT_W-1:0]    ltot, rtot;
  logic signed [PROD_W-1:0]   lmix, rmix;
  logic signed [SAMPLE_W-1:0] lsat, rsat;
  logic signed [7:0]          sweep_step;

  wsm_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  assign req_fire   = req.valid && req.ready;
  assign tick_fire  = req_fire && (req.req_type == REQ_TICK);
  assign write_fire = req_fire && (req.req_type == REQ_WRITE);
  assign out_free   = !out_valid || res.ready;

  assign cfg.ready        = 1'b1;
  assign req.ready        = (state == ST_IDLE);
  assign res.valid        = out_valid;
  assign res.left_sample  = out_left;
  assign res.right_sample = out_right;

  // Decode the current channel's play condition
  always_comb begin
    cur_set   = ch_set[ch];
    voice_on  = mix_set[MIX_VOICE_ON] && mix_set[MIX_VOICE_EN];
    sweep_on  = sweep_set[SWP_ON_BIT];
    ch_active = cur_set[CH_ON_BIT] && mix_set[MIX_EN_LSB + 32'(ch)]
                && !(ch == VOICE_CH && voice_on)
                && !(ch == SWEEP_CH && sweep_on && !mix_set[MIX_SWEEP_EN]);
    cur_freq  = (ch == SWEEP_CH) ? swept_freq : cur_set[CH_FREQ_LSB +: FREQ_W];
  end

  // Scale the fetched step by both volumes
  always_comb begin
    nib      = rd_ok ? (idx[0] ? rd_byte[7:4] : rd_byte[3:0]) : STEP_CENTRE;
    step_val = $signed({1'b0, nib}) - $signed({1'b0, STEP_CENTRE});
    lprod    = step_val * $signed({1'b0, cur_set[CH_LVOL_LSB +: VOL_W]});
    rprod    = step_val * $signed({1'b0, cur_set[CH_RVOL_LSB +: VOL_W]});
  end

  // Add voice, apply master volume and saturate
  always_comb begin
    ltot = TOT_W'(lsum) + TOT_W'(voice);
    rtot = TOT_W'(rsum) + TOT_W'(voice);
    lmix = ltot * $signed({1'b0, mvol});
    rmix = rtot * $signed({1'b0, mvol});
    if (lmix > PROD_W'(32767))       lsat = 16'sh7fff;
    else if (lmix < -PROD_W'(32768)) lsat = -16'sh8000;
    else                             lsat = SAMPLE_W'(lmix);
    if (rmix > PROD_W'(32767))       rsat = 16'sh7fff;
    else if (rmix < -PROD_W'(32768)) rsat = -16'sh8000;
    else                             rsat = SAMPLE_W'(rmix);
  end

  assign sweep_step = $signed(sweep_set[SWP_STEP_LSB +: 8]);

  // Next state and divider start
  always_comb begin
    state_next        = state;
    div_cmd.start     = 1'b0;
    div_cmd.phase     = phase_count[ch];
    div_cmd.divisor   = FREQ_BASE - {1'b0, cur_freq};
    unique case (state)
      ST_IDLE: begin
        if (tick_fire) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (ch_active) begin
          div_cmd.start = 1'b1;
          state_next    = ST_DIV;
        end else if (ch == LAST_CH) begin
          state_next = ST_MIX;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_READ;
      end
      ST_READ: state_next = ST_ACC;
      ST_ACC:  state_next = (ch == LAST_CH) ? ST_MIX : ST_CHECK;
      ST_MIX: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Write configuration registers and run the sweep on each tick while it is on with a nonzero step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) ch_set[i] <= '0;
      sweep_set  <= '0;
      mix_set    <= MIX_SET_W'(126);
      mvol       <= MVOL_W'(4);
      swept_freq <= '0;
      sweep_cnt  <= '0;
    end else begin
      if (tick_fire && sweep_on && sweep_step != 8'sd0) begin
        if (sweep_cnt < 0) begin
          sweep_cnt  <= $signed({1'b0, sweep_set[SWP_PER_LSB +: 13]}) - 14'sd1;
          swept_freq <= swept_freq + FREQ_W'(sweep_step);
        end else begin
          sweep_cnt <= sweep_cnt - 14'sd1;
        end
      end
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.addr) inside
          REG_CH0, REG_CH1, REG_CH2, REG_CH3: begin
            ch_set[cfg.addr[CH_W-1:0]] <= cfg.data[CH_SET_W-1:0];
            if (cfg.addr == REG_CH2) swept_freq <= cfg.data[FREQ_W-1:0];
          end
          REG_SWEEP: sweep_set <= cfg.data[SWEEP_SET_W-1:0];
          REG_MIX:   mix_set   <= cfg.data[MIX_SET_W-1:0];
          REG_MVOL:  mvol      <= cfg.data[MVOL_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  // Write wave bytes and read one byte per playing channel
  always_ff @(posedge clk) begin
    if (write_fire) wmem[req.wave_addr] <= req.wave_data;
    if (state == ST_READ) rd_byte <= wmem[{ch, idx[STEP_W-1:1]}];
  end

  // Track which wave bytes have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (write_fire) wvalid[req.wave_addr] <= 1'b1;
      if (state == ST_READ) rd_ok <= wvalid[{ch, idx[STEP_W-1:1]}];
    end
  end

  // Advance channel state: phase, last step, channel index
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        phase_count[i] <= '0;
        last_step[i]   <= '0;
      end
      ch <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (tick_fire) ch <= '0;
        end
        ST_CHECK: begin
          if (!ch_active && ch != LAST_CH) ch <= ch + 1'b1;
        end
        ST_READ: begin
          if (idx == '0 && last_step[ch] != '0) phase_count[ch] <= PHASE_W'(1);
          else phase_count[ch] <= phase_count[ch] + 1'b1;
          last_step[ch] <= idx;
        end
        ST_ACC: begin
          if (ch != LAST_CH) ch <= ch + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Capture the voice term, the step index and the channel sums
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      lsum  <= '0;
      rsum  <= '0;
      voice <= voice_on ? $signed({~req.voice_sample[7], req.voice_sample[6:0]}) : 8'sd0;
    end
    if (state == ST_DIV && div_rsp.done) idx <= div_rsp.step;
    if (state == ST_ACC) begin
      lsum <= lsum + SUM_W'(lprod);
      rsum <= rsum + SUM_W'(rprod);
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_MIX && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MIX && out_free) begin
      out_left  <= lsat;
      out_right <= rsat;
    end
  end

endmodule

### design/wsm_checker.sv
// Port-level checker for the wavetable sound mixer, with its bind.
`include "wavetable_sound_mixer_defines.svh"

module wsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_type,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] left_sample,
  input logic [15:0] right_sample
);
  import wsm_pkg::*;

  // A stalled result holds its value
  `WSM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(left_sample) && $stable(right_sample), "stalled result changed")

  // A tick keeps the request side busy while the channels are worked
  `WSM_ASSERT_NEXT(a_tick_busy, req_valid && req_ready && req_type == REQ_TICK, !req_ready, "ready right after a tick")

  // A wave write does not make the request side busy
  `WSM_ASSERT_NEXT(a_write_quick, req_valid && req_ready && req_type == REQ_WRITE, req_ready, "busy after a wave write")

  // A new result only appears at the end of tick work
  `WSM_ASSERT_SAME(a_res_from_tick, $rose(res_valid), !$past(req_ready), "result without tick work")

endmodule

bind wavetable_sound_mixer wsm_checker u_wsm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_type     (req.req_type),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .left_sample  (res.left_sample),
  .right_sample (res.right_sample)
);
